// ===== design/fdf_pkg.sv =====
package fdf_pkg;

   localparam int unsigned MAX_WIDTH_DEFAULT = 63;
   localparam int unsigned FIELD_BITS = 6;
   localparam int unsigned MAG_BITS = 32;
   localparam int unsigned DIGITS = 10;
   localparam int unsigned CNT_BITS = $clog2(MAG_BITS);
   localparam int unsigned PTR_BITS = $clog2(DIGITS);

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_PLUS = 8'h2b;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LOWER_D = 8'h64;
   localparam logic [7:0] CHAR_LOWER_I = 8'h69;

   typedef enum logic [2:0] {
      ST_TEXT,
      ST_SPEC,
      ST_WAIT,
      ST_CONV,
      ST_SIZE,
      ST_LEAD,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_BYTE,
      EMIT_SPACE,
      EMIT_SIGN,
      EMIT_DIGIT
   } emit_type;

   typedef struct packed {
      logic     spec_clear;
      logic     spec_update;
      logic     load_arg;
      logic     conv_step;
      logic     size;
      logic     pad_dec;
      logic     digit_dec;
      emit_type emit_kind;
      logic     emit_last;
   } cmd_type;

   typedef struct packed {
      logic is_pct;
      logic is_conv;
      logic is_di;
      logic conv_done;
      logic pad_zero;
      logic pad_one;
      logic dp_zero;
      logic has_sign;
      logic left_align;
      logic out_free;
   } status_type;

   function automatic logic is_conv_letter(input logic [7:0] b);
      logic hit;
      case (b) inside
         8'h73, 8'h53, 8'h70, 8'h64, 8'h44, 8'h69, 8'h6f,
         8'h4f, 8'h75, 8'h55, 8'h78, 8'h58, 8'h63, 8'h43: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

// ===== design/format_string_decimal_formatter_unit.sv =====
// Streaming decimal field formatter. Requests carry either a format byte (action 0) or a
// signed 32-bit argument (action 1); each result is one output character, with last set on
// the final character a request causes. A 'd' or 'i' argument is converted by a
// shift-and-add-3 binary-to-BCD unit that handles one magnitude bit per cycle; the
// field is then sized, leading padding is decided, and the output characters (up to 63)
// follow one per cycle while the output is not stalled. No request is taken while an
// argument is being printed.
module format_string_decimal_formatter_unit #(
   parameter int unsigned MAX_WIDTH = fdf_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [7:0]         req_fmt_byte,
   input  logic signed [31:0] req_arg_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_char,
   output logic               rsp_last
);

   fdf_pkg::cmd_type    cmd_ctrl;
   fdf_pkg::cmd_type    cmd;
   fdf_pkg::status_type status;
   logic                trail_pending;
   logic                ctrl_stall;
   logic                trail_busy;

   fdf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid && !trail_busy),
      .req_stall  (ctrl_stall),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd_ctrl)
   );

   fdf_trail u_trail (
      .clock         (clock),
      .reset         (reset),
      .enable        (1'b1),
      .trail_pending (trail_pending),
      .status        (status),
      .cmd_ctrl      (cmd_ctrl),
      .cmd           (cmd),
      .busy          (trail_busy)
   );

   fdf_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_fmt_byte  (req_fmt_byte),
      .req_arg_value (req_arg_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last      (rsp_last),
      .cmd           (cmd),
      .status        (status),
      .trail_pending (trail_pending)
   );

   assign req_stall = ctrl_stall || trail_busy;

endmodule

// ===== design/fdf_ctrl.sv =====
module fdf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  fdf_pkg::status_type status,
   output fdf_pkg::cmd_type    cmd
);

   fdf_pkg::state_type state_ff;
   fdf_pkg::state_type state_in;
   logic               parse_state;
   logic               accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fdf_pkg::ST_TEXT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign parse_state = (state_ff == fdf_pkg::ST_TEXT) || (state_ff == fdf_pkg::ST_SPEC) ||
                        (state_ff == fdf_pkg::ST_WAIT);
   assign req_stall = !parse_state || !status.out_free;
   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.emit_kind = fdf_pkg::EMIT_NONE;
      unique case (state_ff)
         fdf_pkg::ST_TEXT, fdf_pkg::ST_WAIT: begin
            if (accept) begin
               if (req_action) begin
                  if (state_ff == fdf_pkg::ST_WAIT) begin
                     cmd.load_arg = 1'b1;
                     state_in = fdf_pkg::ST_CONV;
                  end
               end else begin
                  cmd.spec_clear = 1'b1;
                  if (status.is_pct) begin
                     state_in = fdf_pkg::ST_SPEC;
                  end else begin
                     cmd.emit_kind = fdf_pkg::EMIT_BYTE;
                     cmd.emit_last = 1'b1;
                     state_in = fdf_pkg::ST_TEXT;
                  end
               end
            end
         end
         fdf_pkg::ST_SPEC: begin
            if (accept && !req_action) begin
               if (status.is_conv) begin
                  if (status.is_di) begin
                     state_in = fdf_pkg::ST_WAIT;
                  end else begin
                     cmd.spec_clear = 1'b1;
                     state_in = fdf_pkg::ST_TEXT;
                  end
               end else begin
                  cmd.spec_update = 1'b1;
               end
            end
         end
         fdf_pkg::ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (status.conv_done) begin
               state_in = fdf_pkg::ST_SIZE;
            end
         end
         fdf_pkg::ST_SIZE: begin
            cmd.size = 1'b1;
            state_in = fdf_pkg::ST_LEAD;
         end
         fdf_pkg::ST_LEAD: begin
            if (status.left_align || status.pad_zero) begin
               state_in = status.has_sign ? fdf_pkg::ST_SIGN : fdf_pkg::ST_DIGIT;
            end else if (status.out_free) begin
               cmd.emit_kind = fdf_pkg::EMIT_SPACE;
               cmd.pad_dec = 1'b1;
            end
         end
         fdf_pkg::ST_SIGN: begin
            if (status.out_free) begin
               cmd.emit_kind = fdf_pkg::EMIT_SIGN;
               state_in = fdf_pkg::ST_DIGIT;
            end
         end
         fdf_pkg::ST_DIGIT: begin
            if (status.out_free) begin
               cmd.emit_kind = fdf_pkg::EMIT_DIGIT;
               if (status.dp_zero) begin
                  if (status.left_align && !status.pad_zero) begin
                     // The trailing padding is sent by the trail sequencer.
                     state_in = fdf_pkg::ST_TEXT;
                  end else begin
                     cmd.emit_last = 1'b1;
                     cmd.spec_clear = 1'b1;
                     state_in = fdf_pkg::ST_TEXT;
                  end
               end else begin
                  cmd.digit_dec = 1'b1;
               end
            end
         end
         default: begin
            state_in = fdf_pkg::ST_TEXT;
         end
      endcase
   end

   a_conv_to_size: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fdf_pkg::ST_CONV) && status.conv_done |=> state_ff == fdf_pkg::ST_SIZE)
      else $error("conversion did not hand over to sizing");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_last |=> state_ff == fdf_pkg::ST_TEXT)
      else $error("final character did not return to plain text");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fdf_pkg::ST_CONV) |-> req_stall)
      else $error("request taken during conversion");

endmodule

// ===== design/fdf_datapath.sv =====
module fdf_datapath #(
   parameter int unsigned MAX_WIDTH = fdf_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_fmt_byte,
   input  logic signed [31:0]  req_arg_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_char,
   output logic                rsp_last,
   input  fdf_pkg::cmd_type    cmd,
   output fdf_pkg::status_type status,
   output logic                trail_pending
);

   logic                                left_ff, left_in;
   logic                                plus_ff, plus_in;
   logic [fdf_pkg::FIELD_BITS-1:0]      width_ff, width_in;
   logic                                closed_ff, closed_in;
   logic                                neg_ff;
   logic                                sign_ff;
   logic [fdf_pkg::MAG_BITS-1:0]        mag_ff;
   logic [3:0]                          bcd_ff [fdf_pkg::DIGITS];
   logic [3:0]                          bcd_in [fdf_pkg::DIGITS];
   logic [3:0]                          adj [fdf_pkg::DIGITS];
   logic [fdf_pkg::CNT_BITS-1:0]        cnt_ff;
   logic [fdf_pkg::FIELD_BITS-1:0]      pad_ff;
   logic [fdf_pkg::PTR_BITS-1:0]        ptr_ff;
   logic [fdf_pkg::PTR_BITS-1:0]        nd;
   logic [fdf_pkg::FIELD_BITS-1:0]      len;
   logic [9:0]                          prod;
   logic                                is_digit;
   logic                                rsp_valid_ff;
   logic [7:0]                          rsp_char_ff;
   logic                                rsp_last_ff;
   logic [7:0]                          char_in;

   assign is_digit = (req_fmt_byte >= fdf_pkg::CHAR_ZERO) && (req_fmt_byte <= fdf_pkg::CHAR_NINE);
   assign prod = ({4'd0, width_ff} << 3) + ({4'd0, width_ff} << 1) +
                 {6'd0, req_fmt_byte[3:0]};

   always_comb begin
      left_in = left_ff;
      plus_in = plus_ff;
      width_in = width_ff;
      closed_in = closed_ff;
      if (cmd.spec_clear) begin
         left_in = 1'b0;
         plus_in = 1'b0;
         width_in = '0;
         closed_in = 1'b0;
      end else if (cmd.spec_update) begin
         if (req_fmt_byte == fdf_pkg::CHAR_MINUS) begin
            left_in = 1'b1;
         end
         if (req_fmt_byte == fdf_pkg::CHAR_PLUS) begin
            plus_in = 1'b1;
         end
         if (is_digit) begin
            if (!closed_ff) begin
               width_in = (prod > 10'(MAX_WIDTH)) ? fdf_pkg::FIELD_BITS'(MAX_WIDTH) :
                          prod[fdf_pkg::FIELD_BITS-1:0];
            end
         end else if ((width_ff != '0) || closed_ff) begin
            closed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 1'b0;
         plus_ff <= 1'b0;
         width_ff <= '0;
         closed_ff <= 1'b0;
      end else begin
         left_ff <= left_in;
         plus_ff <= plus_in;
         width_ff <= width_in;
         closed_ff <= closed_in;
      end
   end

   // One double-dabble step: correct each BCD digit, then shift one magnitude bit in.
   always_comb begin
      for (int i = 0; i < fdf_pkg::DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
      bcd_in[0] = {adj[0][2:0], mag_ff[fdf_pkg::MAG_BITS-1]};
      for (int i = 1; i < fdf_pkg::DIGITS; i++) begin
         bcd_in[i] = {adj[i][2:0], adj[i-1][3]};
      end
   end

   always_comb begin
      nd = fdf_pkg::PTR_BITS'(1);
      for (int i = 0; i < fdf_pkg::DIGITS; i++) begin
         if (bcd_ff[i] != 4'd0) begin
            nd = fdf_pkg::PTR_BITS'(i + 1);
         end
      end
      len = fdf_pkg::FIELD_BITS'(nd) + fdf_pkg::FIELD_BITS'(neg_ff || plus_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_arg) begin
         neg_ff <= req_arg_value[31];
         mag_ff <= req_arg_value[31] ? 32'(-req_arg_value) : 32'(req_arg_value);
         for (int i = 0; i < fdf_pkg::DIGITS; i++) begin
            bcd_ff[i] <= 4'd0;
         end
      end else if (cmd.conv_step) begin
         mag_ff <= mag_ff << 1;
         bcd_ff <= bcd_in;
      end
      if (cmd.size) begin
         sign_ff <= neg_ff || plus_ff;
         ptr_ff <= nd - fdf_pkg::PTR_BITS'(1);
         pad_ff <= (width_ff > len) ? width_ff - len : '0;
      end else begin
         if (cmd.pad_dec) begin
            pad_ff <= pad_ff - fdf_pkg::FIELD_BITS'(1);
         end
         if (cmd.digit_dec) begin
            ptr_ff <= ptr_ff - fdf_pkg::PTR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.load_arg) begin
         cnt_ff <= '0;
      end else if (cmd.conv_step) begin
         cnt_ff <= cnt_ff + fdf_pkg::CNT_BITS'(1);
      end
   end

   always_comb begin
      case (cmd.emit_kind)
         fdf_pkg::EMIT_BYTE:  char_in = req_fmt_byte;
         fdf_pkg::EMIT_SIGN:  char_in = neg_ff ? fdf_pkg::CHAR_MINUS : fdf_pkg::CHAR_PLUS;
         fdf_pkg::EMIT_DIGIT: char_in = {4'h3, bcd_ff[ptr_ff]};
         default:             char_in = fdf_pkg::CHAR_SPACE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_kind != fdf_pkg::EMIT_NONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit_kind != fdf_pkg::EMIT_NONE) begin
         rsp_char_ff <= char_in;
         rsp_last_ff <= cmd.emit_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last = rsp_last_ff;
   assign trail_pending = left_ff && (pad_ff != '0);

   assign status.is_pct = (req_fmt_byte == fdf_pkg::CHAR_PERCENT);
   assign status.is_conv = fdf_pkg::is_conv_letter(req_fmt_byte);
   assign status.is_di = (req_fmt_byte == fdf_pkg::CHAR_LOWER_D) ||
                         (req_fmt_byte == fdf_pkg::CHAR_LOWER_I);
   assign status.conv_done = (cnt_ff == fdf_pkg::CNT_BITS'(fdf_pkg::MAG_BITS - 1));
   assign status.pad_zero = (pad_ff == '0);
   assign status.pad_one = (pad_ff == fdf_pkg::FIELD_BITS'(1));
   assign status.dp_zero = (ptr_ff == '0);
   assign status.has_sign = sign_ff;
   assign status.left_align = left_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   a_width_bound: assert property (@(posedge clock) disable iff (reset)
      width_ff <= fdf_pkg::FIELD_BITS'(MAX_WIDTH))
      else $error("field width above its limit");

   a_digit_ptr: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_kind == fdf_pkg::EMIT_DIGIT) |-> ptr_ff < fdf_pkg::PTR_BITS'(fdf_pkg::DIGITS))
      else $error("digit pointer outside the BCD register");

endmodule

// ===== design/fdf_trail.sv =====
module fdf_trail (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                trail_pending,
   input  fdf_pkg::status_type status,
   input  fdf_pkg::cmd_type    cmd_ctrl,
   output fdf_pkg::cmd_type    cmd,
   output logic                busy
);

   logic active_ff, active_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   assign busy = active_ff;

   always_comb begin
      active_in = active_ff;
      cmd = cmd_ctrl;
      if (active_ff) begin
         cmd = '0;
         cmd.emit_kind = fdf_pkg::EMIT_NONE;
         if (status.out_free) begin
            cmd.emit_kind = fdf_pkg::EMIT_SPACE;
            cmd.pad_dec = 1'b1;
            if (status.pad_one) begin
               cmd.emit_last = 1'b1;
               cmd.spec_clear = 1'b1;
               active_in = 1'b0;
            end
         end
      end else if (enable && (cmd_ctrl.emit_kind == fdf_pkg::EMIT_DIGIT) && status.dp_zero &&
                   trail_pending) begin
         active_in = 1'b1;
      end
   end

   a_trail_ends: assert property (@(posedge clock) disable iff (reset)
      active_ff && status.out_free && status.pad_one |=> !active_ff)
      else $error("trailing padding did not finish");

endmodule
